// ===== src/ucb_pkg.sv =====
// ----------------------------------------------------------------------------
// ucb_pkg
// Shared constants and types for the UCB1 child select unit.
// ----------------------------------------------------------------------------
package ucb_pkg;

   localparam int MAX_CHILDREN = 256;
   localparam int SEEN_W       = $clog2(MAX_CHILDREN + 1);

   localparam int REWARD_W     = 32;
   localparam int VISITS_W     = 32;
   localparam int INDEX_W      = 8;
   localparam int SCORE_W      = 48;
   localparam int GAIN_W       = 24;
   localparam int TOTAL_W      = 32;

   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_GAIN  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TOTAL = 8'd1;

   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd92682;
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd1;

   // ln 2 in Q0.32
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = 48'sh7FFF_FFFF_FFFF;

   typedef struct packed {
      logic start;
      logic ack;
   } score_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } score_sts_type;

endpackage

// ===== src/ucb_req_if.sv =====
// ----------------------------------------------------------------------------
// ucb_req_if
// Child transaction channel: reward sum, visit count and end-of-run mark.
// ----------------------------------------------------------------------------
interface ucb_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ucb_pkg::REWARD_W-1:0] child_reward;
   logic        [ucb_pkg::VISITS_W-1:0] child_visits;
   logic                                last_child;

   modport source (output valid, output child_reward, output child_visits,
                   output last_child, input ready);
   modport sink   (input valid, input child_reward, input child_visits,
                   input last_child, output ready);
endinterface

// ----------------------------------------------------------------------------
// ucb_rsp_if
// Result transaction channel: best child index, its score, overflow flag.
// ----------------------------------------------------------------------------
interface ucb_rsp_if;
   logic                               valid;
   logic                               ready;
   logic        [ucb_pkg::INDEX_W-1:0] best_index;
   logic signed [ucb_pkg::SCORE_W-1:0] best_score;
   logic                               run_overflow;

   modport source (output valid, output best_index, output best_score,
                   output run_overflow, input ready);
   modport sink   (input valid, input best_index, input best_score,
                   input run_overflow, output ready);
endinterface

// ===== src/ucb_score_unit.sv =====
// ----------------------------------------------------------------------------
// ucb_score_unit
// Sequenced UCB1 scorer: one multiplier and one subtractor shared by the
// log2 squarings, both restoring divisions and the integer square root.
// ----------------------------------------------------------------------------
module ucb_score_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  ucb_pkg::score_ctl_type              ctl,
   output ucb_pkg::score_sts_type              sts,
   input  logic signed [ucb_pkg::REWARD_W-1:0] reward,
   input  logic        [ucb_pkg::VISITS_W-1:0] visits,
   input  logic        [ucb_pkg::GAIN_W-1:0]   gain,
   input  logic        [ucb_pkg::TOTAL_W-1:0]  total,
   input  logic                                ln_flush,
   output logic signed [ucb_pkg::SCORE_W-1:0]  score
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_NORM  = 4'd1;
   localparam logic [3:0] S_SQR   = 4'd2;
   localparam logic [3:0] S_LNMUL = 4'd3;
   localparam logic [3:0] S_LOADR = 4'd4;
   localparam logic [3:0] S_DIVR  = 4'd5;
   localparam logic [3:0] S_SQRT  = 4'd6;
   localparam logic [3:0] S_EXPL  = 4'd7;
   localparam logic [3:0] S_DIVM  = 4'd8;
   localparam logic [3:0] S_SUM   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] x_ff, x_in;
   logic [4:0]  k_ff, k_in;
   logic [20:0] log_ff, log_in;
   logic [20:0] ln_ff, ln_in;
   logic        ln_valid_ff, ln_valid_in;
   logic [36:0] dvd_ff, dvd_in;
   logic [31:0] rem_ff, rem_in;
   logic [37:0] v_ff, v_in;
   logic [36:0] res_ff, res_in;
   logic [36:0] bit_ff, bit_in;
   logic [27:0] explore_ff, explore_in;
   logic signed [ucb_pkg::SCORE_W-1:0] score_ff, score_in;
   logic [31:0] w_ff, w_in;
   logic [31:0] n_ff, n_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [37:0] sub_a, sub_b;
   logic [38:0] diff;
   logic        ge;
   logic [31:0] mag;
   logic [47:0] mean;

   // shared units
   assign prod = mul_a * mul_b;
   assign diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge   = ~diff[38];
   assign mag  = w_ff[31] ? (~w_ff + 32'd1) : w_ff;
   assign mean = w_ff[31] ? (48'd0 - {16'd0, dvd_ff[31:0]}) : {16'd0, dvd_ff[31:0]};

   always_comb begin
      mul_a = x_ff;
      mul_b = x_ff;
      case (state_ff)
         S_LNMUL: begin
            mul_a = {11'd0, log_ff};
            mul_b = ucb_pkg::LN2_Q32;
         end
         S_EXPL: begin
            mul_a = {8'd0, gain};
            mul_b = {13'd0, res_ff[18:0]};
         end
         default: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
      endcase
   end

   always_comb begin
      if (state_ff == S_SQRT) begin
         sub_a = v_ff;
         sub_b = {1'b0, res_ff | bit_ff};
      end else begin
         sub_a = {5'd0, rem_ff, dvd_ff[36]};
         sub_b = {6'd0, n_ff};
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      x_in        = x_ff;
      k_in        = k_ff;
      log_in      = log_ff;
      ln_in       = ln_ff;
      ln_valid_in = ln_valid_ff & ~ln_flush;
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      v_in        = v_ff;
      res_in      = res_ff;
      bit_in      = bit_ff;
      explore_in  = explore_ff;
      score_in    = score_ff;
      w_in        = w_ff;
      n_in        = n_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               w_in = reward;
               n_in = visits;
               if (visits == 32'd0) begin
                  score_in = ucb_pkg::SCORE_MAX;
                  state_in = S_DONE;
               end else if (ln_valid_ff) begin
                  state_in = S_LOADR;
               end else if (total <= 32'd1) begin
                  ln_in       = 21'd0;
                  ln_valid_in = 1'b1;
                  state_in    = S_LOADR;
               end else begin
                  x_in     = total;
                  k_in     = 5'd31;
                  state_in = S_NORM;
               end
            end
         end
         S_NORM: begin
            // one place per cycle until the top bit lands in bit 31
            if (x_ff[31]) begin
               log_in   = {k_ff, 16'd0};
               cnt_in   = 6'd15;
               state_in = S_SQR;
            end else begin
               x_in = {x_ff[30:0], 1'b0};
               k_in = k_ff - 5'd1;
            end
         end
         S_SQR: begin
            x_in = prod[63] ? prod[63:32] : prod[62:31];
            if (prod[63]) begin
               log_in[cnt_ff[3:0]] = 1'b1;
            end
            if (cnt_ff == 6'd0) begin
               state_in = S_LNMUL;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_LNMUL: begin
            ln_in       = prod[52:32];
            ln_valid_in = 1'b1;
            state_in    = S_LOADR;
         end
         S_LOADR: begin
            dvd_in   = {ln_ff, 16'd0};
            rem_in   = 32'd0;
            cnt_in   = 6'd36;
            state_in = S_DIVR;
         end
         S_DIVR, S_DIVM: begin
            rem_in = ge ? diff[31:0] : sub_a[31:0];
            dvd_in = {dvd_ff[35:0], ge};
            if (cnt_ff == 6'd0) begin
               if (state_ff == S_DIVR) begin
                  v_in     = {1'b0, dvd_ff[35:0], ge};
                  res_in   = 37'd0;
                  bit_in   = 37'd1 << 36;
                  cnt_in   = 6'd18;
                  state_in = S_SQRT;
               end else begin
                  state_in = S_SUM;
               end
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_SQRT: begin
            // res and bit never overlap here, so OR stands for the add
            if (ge) begin
               v_in   = diff[37:0];
               res_in = (res_ff >> 1) | bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (cnt_ff == 6'd0) begin
               state_in = S_EXPL;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_EXPL: begin
            explore_in = prod[43:16];
            dvd_in     = {5'd0, mag};
            rem_in     = 32'd0;
            cnt_in     = 6'd36;
            state_in   = S_DIVM;
         end
         S_SUM: begin
            score_in = $signed(mean + {20'd0, explore_ff});
            state_in = S_DONE;
         end
         S_DONE: begin
            if (ctl.ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ln_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ln_valid_ff <= ln_valid_in;
      end
      cnt_ff     <= cnt_in;
      x_ff       <= x_in;
      k_ff       <= k_in;
      log_ff     <= log_in;
      ln_ff      <= ln_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      v_ff       <= v_in;
      res_ff     <= res_in;
      bit_ff     <= bit_in;
      explore_ff <= explore_in;
      score_ff   <= score_in;
      w_ff       <= w_in;
      n_ff       <= n_in;
   end

   assign sts.idle = (state_ff == S_IDLE);
   assign sts.done = (state_ff == S_DONE);
   assign score    = score_ff;

endmodule

// ===== src/ucb1_child_select_unit.sv =====
// ----------------------------------------------------------------------------
// ucb1_child_select_unit
// UCB1 child selection: scores streamed children, reports the best per run.
// ----------------------------------------------------------------------------
// Each child transaction is scored on one shared multiplier/subtractor under
// a sequencer, and the block is not ready until the score is folded into the
// running best. A child with visits goes through two 37-step restoring
// divisions and a 19-step square root; a child with zero visits, or one
// arriving on an overflowed run, needs neither. After reset or a
// total_visits write, the first child with visits also pays for ln(T) when
// T exceeds one: normalising shifts, 16 squarings and one multiply. A result
// waits in its own register, so scoring of the next child proceeds while it
// is held; only the end of the following run waits for that result to be
// taken.
module ucb1_child_select_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   ucb_req_if.sink                              req_ch,
   ucb_rsp_if.source                            rsp_ch,
   input  logic                                 csr_write_enable,
   input  logic [ucb_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ucb_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   logic [ucb_pkg::GAIN_W-1:0]  gain_ff;
   logic [ucb_pkg::TOTAL_W-1:0] total_ff;

   logic                        busy_ff, busy_in;
   logic                        last_ff, skip_ff;
   logic signed [ucb_pkg::SCORE_W-1:0] best_ff, best_in;
   logic [ucb_pkg::INDEX_W-1:0] idx_ff, idx_in;
   logic [ucb_pkg::SEEN_W-1:0]  seen_ff, seen_in;
   logic                        ovf_ff, ovf_in;

   logic                        rsp_valid_ff;
   logic [ucb_pkg::INDEX_W-1:0] rsp_idx_ff;
   logic signed [ucb_pkg::SCORE_W-1:0] rsp_score_ff;
   logic                        rsp_ovf_ff;

   ucb_pkg::score_ctl_type      ctl;
   ucb_pkg::score_sts_type      sts;
   logic signed [ucb_pkg::SCORE_W-1:0] score;
   logic                        accept, full, commit, ln_flush;

   assign accept   = req_ch.valid & req_ch.ready;
   assign full     = (seen_ff == ucb_pkg::SEEN_W'(ucb_pkg::MAX_CHILDREN));
   assign commit   = busy_ff & (skip_ff | sts.done)
                     & (~last_ff | ~rsp_valid_ff | rsp_ch.ready);
   assign ln_flush = csr_write_enable & (csr_index == ucb_pkg::REG_TOTAL);

   assign ctl.start = accept & ~full;
   assign ctl.ack   = commit & ~skip_ff;

   assign req_ch.ready = ~busy_ff & sts.idle;

   ucb_score_unit u_score (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sts      (sts),
      .reward   (req_ch.child_reward),
      .visits   (req_ch.child_visits),
      .gain     (gain_ff),
      .total    (total_ff),
      .ln_flush (ln_flush),
      .score    (score)
   );

   always_comb begin
      busy_in = busy_ff;
      best_in = best_ff;
      idx_in  = idx_ff;
      seen_in = seen_ff;
      ovf_in  = ovf_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (commit) begin
         busy_in = 1'b0;
         if (skip_ff) begin
            ovf_in = 1'b1;
         end else begin
            // strict compare keeps the earlier child on a tie
            if (seen_ff == '0 || score > best_ff) begin
               best_in = score;
               idx_in  = seen_ff[ucb_pkg::INDEX_W-1:0];
            end
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= ucb_pkg::GAIN_RESET;
         total_ff     <= ucb_pkg::TOTAL_RESET;
         busy_ff      <= 1'b0;
         best_ff      <= '0;
         idx_ff       <= '0;
         seen_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable && csr_index == ucb_pkg::REG_GAIN) begin
            gain_ff <= csr_write_data[ucb_pkg::GAIN_W-1:0];
         end
         if (ln_flush) begin
            total_ff <= csr_write_data[ucb_pkg::TOTAL_W-1:0];
         end
         busy_ff <= busy_in;
         if (commit && last_ff) begin
            best_ff      <= '0;
            idx_ff       <= '0;
            seen_ff      <= '0;
            ovf_ff       <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else begin
            best_ff <= best_in;
            idx_ff  <= idx_in;
            seen_ff <= seen_in;
            ovf_ff  <= ovf_in;
            if (rsp_ch.ready) begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end
      if (accept) begin
         last_ff <= req_ch.last_child;
         skip_ff <= full;
      end
      if (commit && last_ff) begin
         rsp_idx_ff   <= idx_in;
         rsp_score_ff <= best_in;
         rsp_ovf_ff   <= ovf_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.best_index   = rsp_idx_ff;
   assign rsp_ch.best_score   = rsp_score_ff;
   assign rsp_ch.run_overflow = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= ucb_pkg::SEEN_W'(ucb_pkg::MAX_CHILDREN))
      else $error("children count beyond limit");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted child not in flight");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> busy_ff)
      else $error("score finished with no child in flight");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      commit && last_ff |=> rsp_valid_ff && seen_ff == '0)
      else $error("end of run did not emit a result");
`endif

endmodule
